// ===== rtl/cspsc_pkg.sv =====
`default_nettype none
package cspsc_pkg;

    localparam logic [31:0] HASH_MULT  = 32'd2654435761;
    localparam int          HASH_CELLS = 4;
    localparam int          CELL_W     = 8;
    localparam int          HCNT_W     = $clog2(HASH_CELLS);

    typedef logic [1:0]  req_type_t;
    typedef logic [31:0] char_t;
    typedef logic [31:0] length_t;

    localparam req_type_t REQ_CLEAR = 2'd0;
    localparam req_type_t REQ_ADD   = 2'd1;
    localparam req_type_t REQ_SCAN  = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/cspsc_req_if.sv =====
`default_nettype none
interface cspsc_req_if;
    import cspsc_pkg::*;

    logic      valid;
    logic      ready;
    req_type_t req_type;
    char_t     char_value;

    modport source (output valid, output req_type, output char_value, input ready);
    modport sink   (input valid, input req_type, input char_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/cspsc_rsp_if.sv =====
`default_nettype none
interface cspsc_rsp_if;
    import cspsc_pkg::*;

    logic    valid;
    logic    ready;
    length_t prefix_length;
    logic    hit_member;
    logic    set_overflow;

    modport source (output valid, output prefix_length, output hit_member,
                    output set_overflow, input ready);
    modport sink   (input valid, input prefix_length, input hit_member,
                    input set_overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/cspsc_ram.sv =====
`default_nettype none
module cspsc_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata_reg
);
    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/cspsc_hash_cell.sv =====
`default_nettype none
module cspsc_hash_cell #(
    parameter int SHIFT = 0
) (
    input  wire logic        clk,
    input  wire logic [31:0] acc_in,
    input  wire logic [7:0]  byte_in,
    output logic      [31:0] acc_reg
);
    import cspsc_pkg::*;

    logic [31:0] prod;
    logic [31:0] term;

    // one byte of the key times the multiplier, placed at this cell's weight
    assign prod = HASH_MULT * 32'(byte_in);
    assign term = prod << SHIFT;

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_in + term;
    end
endmodule
`default_nettype wire

// ===== rtl/char_set_prefix_scanner_top.sv =====
// Sequence: an add or a nonzero scan waits in the hash state while the key ripples through the cell row,
// then probes the table, each probe a read and a compare; a member hit goes on to the emit state.
// A terminator scan goes straight to the emit state, which holds until the output register is free.
// The block takes one item at a time: the input is held off until the current item is done.
// A NUL add or an unused code is dropped without a probe.
// Reset and a clear request both run a sweep over all 2^TABLE_LOG2 slots that zeroes the table,
// with the input held off; counters and the overflow flag are zero after reset.
`default_nettype none
module char_set_prefix_scanner_top #(
    parameter int TABLE_LOG2 = 10
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cspsc_req_if.sink  req,
    cspsc_rsp_if.source rsp
);
    import cspsc_pkg::*;

    localparam int                TSIZE     = 1 << TABLE_LOG2;
    localparam logic [TABLE_LOG2-1:0] TMASK = TABLE_LOG2'(TSIZE - 1);
    localparam logic [TABLE_LOG2-1:0] SET_LIMIT = TABLE_LOG2'(TSIZE >> 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_HOME  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_CHK   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [TABLE_LOG2-1:0] clr_reg, clr_next;
    logic [HCNT_W-1:0]     hcnt_reg, hcnt_next;
    logic [TABLE_LOG2-1:0] pos_reg, pos_next;
    logic [TABLE_LOG2-1:0] step_reg, step_next;
    logic [TABLE_LOG2-1:0] count_reg, count_next;
    length_t               scan_reg, scan_next;
    logic                  ovf_reg, ovf_next;
    logic                  is_scan_reg, is_scan_next;
    logic                  hit_reg, hit_next;
    char_t                 char_reg, char_next;
    logic                  out_valid_reg, out_valid_next;
    length_t               out_len_reg, out_len_next;
    logic                  out_hit_reg, out_hit_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic                  ram_we;
    logic [TABLE_LOG2-1:0] ram_waddr;
    char_t                 ram_wdata;
    logic [TABLE_LOG2-1:0] ram_raddr;
    char_t                 ram_rdata;

    logic [31:0]           acc [HASH_CELLS];
    logic [TABLE_LOG2-1:0] home;
    logic                  slot_free;

    // multiplicative hash, one byte of the key per cell
    for (genvar j = 0; j < HASH_CELLS; j++)
    begin : g_cell
        cspsc_hash_cell #(
            .SHIFT(j * CELL_W)
        ) u_cell (
            .clk    (clk),
            .acc_in (j == 0 ? 32'd0 : acc[(j == 0) ? 0 : j - 1]),
            .byte_in(char_reg[j*CELL_W +: CELL_W]),
            .acc_reg(acc[j])
        );
    end

    assign home = acc[HASH_CELLS-1][31 -: TABLE_LOG2];

    cspsc_ram #(
        .DATA_W(32),
        .ADDR_W(TABLE_LOG2)
    ) u_table (
        .clk      (clk),
        .we       (ram_we),
        .waddr    (ram_waddr),
        .wdata    (ram_wdata),
        .raddr    (ram_raddr),
        .rdata_reg(ram_rdata)
    );

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.prefix_length = out_len_reg;
    assign rsp.hit_member    = out_hit_reg;
    assign rsp.set_overflow  = out_ovf_reg;

    assign slot_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        hcnt_next      = hcnt_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        ovf_next       = ovf_reg;
        is_scan_next   = is_scan_reg;
        hit_next       = hit_reg;
        char_next      = char_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_len_next   = out_len_reg;
        out_hit_next   = out_hit_reg;
        out_ovf_next   = out_ovf_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = char_reg;
        ram_raddr      = pos_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == TMASK)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    char_next    = req.char_value;
                    is_scan_next = (req.req_type == REQ_SCAN);
                    hcnt_next    = '0;
                    unique case (req.req_type)
                        REQ_CLEAR:
                        begin
                            clr_next   = '0;
                            count_next = '0;
                            scan_next  = '0;
                            ovf_next   = 1'b0;
                            state_next = S_CLEAR;
                        end
                        REQ_ADD:
                        begin
                            if (req.char_value != '0)
                            begin
                                state_next = S_HASH;
                            end
                        end
                        REQ_SCAN:
                        begin
                            if (req.char_value == '0)
                            begin
                                hit_next   = 1'b0;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_HASH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_HASH:
            begin
                // wait for the partial sums to ripple through the row
                hcnt_next = hcnt_reg + 1'b1;
                if (hcnt_reg == HCNT_W'(HASH_CELLS - 1))
                begin
                    state_next = S_HOME;
                end
            end
            S_HOME:
            begin
                ram_raddr  = home;
                pos_next   = home;
                step_next  = '0;
                state_next = S_CHK;
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (ram_rdata == char_reg)
                begin
                    if (is_scan_reg)
                    begin
                        hit_next   = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (ram_rdata == '0 || step_reg == TMASK)
                begin
                    // not a member: an empty slot ends the probe, or the sequence is exhausted
                    state_next = S_IDLE;
                    if (is_scan_reg)
                    begin
                        if (scan_reg != '1)
                        begin
                            scan_next = scan_reg + 1'b1;
                        end
                    end
                    else if (count_reg >= SET_LIMIT || ram_rdata != '0)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    pos_next   = pos_reg + step_reg + 1'b1;
                    step_next  = step_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = scan_reg;
                    out_hit_next   = hit_reg;
                    out_ovf_next   = ovf_reg;
                    scan_next      = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            hcnt_reg      <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            hcnt_reg      <= hcnt_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        step_reg    <= step_next;
        is_scan_reg <= is_scan_next;
        hit_reg     <= hit_next;
        char_reg    <= char_next;
        out_len_reg <= out_len_next;
        out_hit_reg <= out_hit_next;
        out_ovf_reg <= out_ovf_next;
    end

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SET_LIMIT)
        else $error("set count above limit");

    a_insert_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK && ram_we) |-> ram_rdata == '0)
        else $error("insert over an occupied slot");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg) == S_EMIT)
        else $error("result raised outside emit");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && clr_reg == TMASK) |=> count_reg == '0 && scan_reg == '0)
        else $error("counters not zero after clear sweep");

endmodule
`default_nettype wire

// ===== sim/prefix_scan_checker.sv =====
module prefix_scan_checker #(
    parameter int TABLE_LOG2 = 10
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cspsc_req_if        req,
    cspsc_rsp_if        rsp,
    output int unsigned mismatches,
    output int unsigned outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import cspsc_pkg::*;

    localparam int unsigned SLOTS     = 1 << TABLE_LOG2;
    localparam int unsigned SET_LIMIT = SLOTS >> 1;

    typedef struct packed {
        length_t prefix_length;
        logic    hit_member;
        logic    set_overflow;
    } scan_stop_t;

    char_t       slot_char [SLOTS];
    int unsigned stored;
    length_t     scanned;
    logic        overflowed;
    int unsigned fails = 0;
    scan_stop_t  stops_due [$];

    function automatic void wipe_set();
        foreach (slot_char[k])
            slot_char[k] = '0;
        stored     = 0;
        scanned    = '0;
        overflowed = 1'b0;
    endfunction

    // Walk the triangular probe sequence from the home slot until the character
    // or an empty slot turns up.
    function automatic bit locate_char(input char_t c, output int unsigned where,
                                       output bit hole);
        char_t       prod;
        int unsigned pos;
        prod  = c * HASH_MULT;
        pos   = prod >> (32 - TABLE_LOG2);
        where = 0;
        hole  = 1'b0;
        for (int unsigned i = 0; i < SLOTS; i++) begin
            if (slot_char[pos & (SLOTS - 1)] == c) begin
                where = pos & (SLOTS - 1);
                return 1'b1;
            end
            if (slot_char[pos & (SLOTS - 1)] == '0) begin
                where = pos & (SLOTS - 1);
                hole  = 1'b1;
                return 1'b0;
            end
            pos = pos + i + 1;
        end
        return 1'b0;
    endfunction

    function automatic bit advance_scanner(input req_type_t kind, input char_t c,
                                           output scan_stop_t stop);
        int unsigned where;
        bit          hole;
        bit          member;
        stop = '0;
        case (kind)
            REQ_CLEAR: wipe_set();
            REQ_ADD:
            begin
                if (c != '0 && !locate_char(c, where, hole))
                begin
                    if (stored >= SET_LIMIT || !hole)
                        overflowed = 1'b1;
                    else
                    begin
                        slot_char[where] = c;
                        stored++;
                    end
                end
            end
            REQ_SCAN:
            begin
                member = 1'b0;
                if (c != '0)
                    member = locate_char(c, where, hole);
                if (c == '0 || member)
                begin
                    stop.prefix_length = scanned;
                    stop.hit_member    = member;
                    stop.set_overflow  = overflowed;
                    scanned            = '0;
                    return 1'b1;
                end
                if (scanned != '1)
                    scanned++;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void flag_field(input string field, input length_t want,
                                       input length_t got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scan_stop_t due;
        scan_stop_t made;
        if (!rst_n)
        begin
            wipe_set();
            stops_due.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (stops_due.size() == 0)
                begin
                    $display("%0t: unexpected result, prefix_length %0d hit_member %0b %s %0b",
                             $time, rsp.prefix_length, rsp.hit_member, "set_overflow",
                             rsp.set_overflow);
                    fails++;
                end
                else
                begin
                    due = stops_due.pop_front();
                    flag_field("prefix_length", due.prefix_length, rsp.prefix_length);
                    flag_field("hit_member", length_t'(due.hit_member),
                               length_t'(rsp.hit_member));
                    flag_field("set_overflow", length_t'(due.set_overflow),
                               length_t'(rsp.set_overflow));
                end
            end
            if (req.valid && req.ready)
            begin
                if (advance_scanner(req.req_type, req.char_value, made))
                    stops_due.push_back(made);
            end
            mismatches  <= fails;
            outstanding <= stops_due.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cspsc_pkg::*;

    localparam int        TABLE_LOG2  = 10;
    localparam int        SLOTS       = 1 << TABLE_LOG2;
    localparam int        SET_LIMIT   = SLOTS >> 1;
    localparam int        ITEM_TARGET = 2000;
    localparam int        LONG_HOLD   = 400;
    localparam int        IDLE_LIMIT  = 20000;
    localparam int        TAIL_CYCLES = 2 * SLOTS + 64;
    localparam req_type_t REQ_UNUSED  = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    cspsc_req_if req ();
    cspsc_rsp_if rsp ();

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned holds_asked = 0;
    char_t       hash_inverse;
    bit          in_set [char_t];
    char_t       members [$];

    char_set_prefix_scanner_top #(.TABLE_LOG2(TABLE_LOG2)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    prefix_scan_checker #(.TABLE_LOG2(TABLE_LOG2)) scan_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Pick a character whose multiplicative hash lands on the given home slot.
    function automatic char_t char_for_slot(input int unsigned slot);
        char_t prod;
        prod = (char_t'(slot) << (32 - TABLE_LOG2))
             | char_t'($urandom_range(1, (1 << (32 - TABLE_LOG2)) - 1));
        return prod * hash_inverse;
    endfunction

    function automatic char_t fresh_char();
        char_t c;
        case ($urandom_range(0, 9))
            0, 1, 2: c = char_for_slot($urandom_range(0, 7));
            3:       c = 32'h1 << $urandom_range(0, 31);
            4:       c = ~(32'h1 << $urandom_range(0, 31));
            default: c = $urandom;
        endcase
        if (c == '0)
            c = 32'h1;
        return c;
    endfunction

    function automatic char_t pick_member();
        return members[$urandom_range(0, members.size() - 1)];
    endfunction

    task automatic offer(input req_type_t kind, input char_t c);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
            if (gap != 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.valid      <= 1'b1;
        req.req_type   <= kind;
        req.char_value <= c;
        do @(posedge clk); while (!req.ready);
        if (kind != REQ_UNUSED)
            items_sent++;
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic add_char(input char_t c);
        offer(REQ_ADD, c);
        if (c != '0 && !in_set.exists(c) && members.size() < SET_LIMIT)
        begin
            in_set[c] = 1'b1;
            members.push_back(c);
        end
    endtask

    task automatic clear_set();
        offer(REQ_CLEAR, $urandom);
        in_set.delete();
        members.delete();
    endtask

    task automatic add_some(input int unsigned n);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0:       add_char('0);
                1, 2:    add_char(members.size() != 0 ? pick_member() : fresh_char());
                default: add_char(fresh_char());
            endcase
        end
    endtask

    task automatic scan_string(input int unsigned len, input bit end_on_member);
        repeat (len) offer(REQ_SCAN, fresh_char());
        if (end_on_member && members.size() != 0)
            offer(REQ_SCAN, pick_member());
        else
            offer(REQ_SCAN, '0);
    endtask

    function automatic int unsigned string_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 8);
    endfunction

    // Receiver: changing ready patterns, plus a long hold-off on request.
    initial
    begin
        int unsigned phase_left;
        int unsigned mode;
        int unsigned holds_served;
        logic [7:0]  mask;
        rsp.ready    = 1'b0;
        phase_left   = 0;
        mode         = 0;
        holds_served = 0;
        mask         = '1;
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode       = $urandom_range(0, 3);
                    mask       = $urandom;
                    phase_left = $urandom_range(16, 160);
                end
                phase_left--;
                case (mode)
                    0:       rsp.ready <= 1'b1;
                    1:       rsp.ready <= $urandom_range(0, 1);
                    2:       rsp.ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        rsp.ready <= mask[0];
                        mask = {mask[0], mask[7:1]};
                    end
                endcase
            end
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        char_t       chain [3];
        bit          filled;
        int unsigned stalls_done;
        int unsigned pick;

        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.req_type   = REQ_CLEAR;
        req.char_value = '0;
        filled         = 1'b0;
        stalls_done    = 0;

        // Odd multiplier: Newton steps give its inverse modulo 2^32.
        hash_inverse = HASH_MULT;
        repeat (5) hash_inverse = hash_inverse * (32'd2 - HASH_MULT * hash_inverse);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        offer(REQ_SCAN, '0);
        add_char('0);
        add_char(32'hFFFF_FFFF);
        add_char(32'h8000_0000);
        add_char(32'h0000_0001);
        add_char(32'hFFFF_FFFF);
        for (int k = 0; k < 3; k++)
        begin
            chain[k] = char_for_slot(5);
            add_char(chain[k]);
        end
        offer(REQ_UNUSED, 32'hFFFF_FFFF);
        offer(REQ_SCAN, 32'h1234_5678);
        offer(REQ_SCAN, 32'hFFFF_FFFE);
        offer(REQ_SCAN, 32'h7FFF_FFFF);
        offer(REQ_SCAN, 32'h8000_0000);
        // member at the tail of a probe chain, right after a stop
        offer(REQ_SCAN, chain[2]);
        offer(REQ_SCAN, 32'hAAAA_AAAA);
        offer(REQ_SCAN, 32'h5555_5555);
        offer(REQ_SCAN, '0);
        // walks the whole chain and misses
        offer(REQ_SCAN, char_for_slot(5));
        offer(REQ_SCAN, 32'h0000_0001);
        clear_set();
        offer(REQ_SCAN, 32'hFFFF_FFFF);
        offer(REQ_SCAN, '0);

        while (items_sent < ITEM_TARGET)
        begin
            if (!filled && items_sent >= 700)
            begin
                // fill to half the table, then push past it
                drain_results();
                clear_set();
                while (members.size() < SET_LIMIT)
                    add_char(fresh_char());
                repeat (3) add_char($urandom | 32'h1);
                add_char(pick_member());
                add_char('0);
                scan_string(string_len(), 1'b1);
                scan_string(string_len(), 1'b0);
                clear_set();
                scan_string(string_len(), 1'b0);
                filled = 1'b1;
            end
            else if (stalls_done < 2 && items_sent >= 300 + stalls_done * 1000)
            begin
                drain_results();
                holds_asked++;
                repeat (8) scan_string($urandom_range(0, 3), 1'b1);
                stalls_done++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    clear_set();
                else if (pick < 60)
                begin
                    add_some($urandom_range(0, 6));
                    scan_string(string_len(), $urandom_range(0, 1));
                end
                else if (pick < 80)
                    scan_string(string_len(), $urandom_range(0, 2) != 0);
                else
                begin
                    case ($urandom_range(0, 7))
                        0:       clear_set();
                        1, 2:    offer(REQ_UNUSED, $urandom);
                        3:       add_char($urandom_range(0, 1) ? char_t'($urandom) : '0);
                        default: offer(REQ_SCAN, $urandom_range(0, 3) ? char_t'($urandom) : '0);
                    endcase
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            if (outstanding != 0)
                $display("%0t: %0d expected results never arrived", $time, outstanding);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
